/* design/rfd_pkg.sv */
// Package for the radio frame deframer: shared types, codes and register map.
// Used by every module of the block and by its checker; depends on nothing.
package rfd_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    typedef enum logic [2:0] {
        REG_SYNC_FIRST    = 3'd0,
        REG_SYNC_SECOND   = 3'd1,
        REG_TYPE_INBOUND  = 3'd2,
        REG_TYPE_OUTBOUND = 3'd3,
        REG_COMMAND_LIMIT = 3'd4,
        REG_ACK_CODE      = 3'd5,
        REG_NACK_CODE     = 3'd6,
        REG_MAX_PAYLOAD   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CHECK   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_CSUM    = 2'd2
    } t_status;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [7:0]  RST_SYNC_FIRST    = 8'd72;
    localparam logic [7:0]  RST_SYNC_SECOND   = 8'd101;
    localparam logic [7:0]  RST_TYPE_INBOUND  = 8'd16;
    localparam logic [7:0]  RST_TYPE_OUTBOUND = 8'd32;
    localparam logic [8:0]  RST_COMMAND_LIMIT = 9'd64;
    localparam logic [15:0] RST_ACK_CODE      = 16'd2570;
    localparam logic [15:0] RST_NACK_CODE     = 16'd65535;
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd255;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  type_inbound;
        logic [7:0]  type_outbound;
        logic [8:0]  command_limit;
        logic [15:0] ack_code;
        logic [15:0] nack_code;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        t_status     status;
        logic [7:0]  msg_type;
        logic [7:0]  command;
        logic [15:0] length;
    } t_rec;

endpackage

/* design/radio_frame_deframer.sv */
// Top level of the radio frame deframer: register file, front part, queue and
// back part. Depends on rfd_pkg, rfd_regs, rfd_front, rfd_queue and rfd_back.
//
//   Channel  Handshake                      Payload
//   input    i_valid / o_ready              i_rx_byte
//   output   o_valid / i_ready              o_item_kind ... o_is_inbound
//   config   psel, penable, pwrite / pready paddr, pwdata, prdata
//
// One byte is accepted per cycle while the four-entry queue has room.
// A result passes through the queue and the output register before it reaches the outputs.
// A stalled output fills the queue; input stalls only once the queue is full.
// Reset is synchronous and needs no clearing pass.
module radio_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_item_kind,
    output logic [7:0]                     o_payload_byte,
    output logic [1:0]                     o_status,
    output logic [7:0]                     o_msg_type,
    output logic [7:0]                     o_command_code,
    output logic [15:0]                    o_length_field,
    output logic                           o_is_ack,
    output logic                           o_is_nack,
    output logic                           o_is_inbound,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rfd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    rfd_pkg::t_cfg w_cfg;
    rfd_pkg::t_rec w_push_rec, w_head_rec;
    logic          w_push, w_pop, w_empty, w_full, w_accept;

    assign o_ready  = !w_full;
    assign w_accept = i_valid && !w_full;

    rfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (w_cfg),
        .o_push    (w_push),
        .o_rec     (w_push_rec)
    );

    rfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    rfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_rec          (w_head_rec),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_item_kind    (o_item_kind),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_msg_type     (o_msg_type),
        .o_command_code (o_command_code),
        .o_length_field (o_length_field),
        .o_is_ack       (o_is_ack),
        .o_is_nack      (o_is_nack),
        .o_is_inbound   (o_is_inbound)
    );

endmodule

/* design/rfd_regs.sv */
// Configuration register file of the radio frame deframer on an APB-style port.
// Depends on rfd_pkg for the register map and the configuration struct.
module rfd_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rfd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output rfd_pkg::t_cfg                    o_cfg
);
    rfd_pkg::t_cfg    r_cfg;
    rfd_pkg::t_cfg    n_cfg;
    rfd_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = rfd_pkg::t_reg_idx'(paddr[rfd_pkg::CFG_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                rfd_pkg::REG_SYNC_FIRST:    n_cfg.sync_first    = pwdata[7:0];
                rfd_pkg::REG_SYNC_SECOND:   n_cfg.sync_second   = pwdata[7:0];
                rfd_pkg::REG_TYPE_INBOUND:  n_cfg.type_inbound  = pwdata[7:0];
                rfd_pkg::REG_TYPE_OUTBOUND: n_cfg.type_outbound = pwdata[7:0];
                rfd_pkg::REG_COMMAND_LIMIT: n_cfg.command_limit = pwdata[8:0];
                rfd_pkg::REG_ACK_CODE:      n_cfg.ack_code      = pwdata[15:0];
                rfd_pkg::REG_NACK_CODE:     n_cfg.nack_code     = pwdata[15:0];
                rfd_pkg::REG_MAX_PAYLOAD:   n_cfg.max_payload   = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rfd_pkg::REG_SYNC_FIRST:    prdata = {24'd0, r_cfg.sync_first};
            rfd_pkg::REG_SYNC_SECOND:   prdata = {24'd0, r_cfg.sync_second};
            rfd_pkg::REG_TYPE_INBOUND:  prdata = {24'd0, r_cfg.type_inbound};
            rfd_pkg::REG_TYPE_OUTBOUND: prdata = {24'd0, r_cfg.type_outbound};
            rfd_pkg::REG_COMMAND_LIMIT: prdata = {23'd0, r_cfg.command_limit};
            rfd_pkg::REG_ACK_CODE:      prdata = {16'd0, r_cfg.ack_code};
            rfd_pkg::REG_NACK_CODE:     prdata = {16'd0, r_cfg.nack_code};
            rfd_pkg::REG_MAX_PAYLOAD:   prdata = {16'd0, r_cfg.max_payload};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= rfd_pkg::RST_SYNC_FIRST;
            r_cfg.sync_second   <= rfd_pkg::RST_SYNC_SECOND;
            r_cfg.type_inbound  <= rfd_pkg::RST_TYPE_INBOUND;
            r_cfg.type_outbound <= rfd_pkg::RST_TYPE_OUTBOUND;
            r_cfg.command_limit <= rfd_pkg::RST_COMMAND_LIMIT;
            r_cfg.ack_code      <= rfd_pkg::RST_ACK_CODE;
            r_cfg.nack_code     <= rfd_pkg::RST_NACK_CODE;
            r_cfg.max_payload   <= rfd_pkg::RST_MAX_PAYLOAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* design/rfd_front.sv */
// Front part of the radio frame deframer: accepts bytes, tracks the packet
// phase, runs the checksums and validates the header. Depends on rfd_pkg.
module rfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  rfd_pkg::t_cfg i_cfg,
    output logic          o_push,
    output rfd_pkg::t_rec o_rec
);
    rfd_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_hidx, n_hidx;
    logic [15:0]      r_cnt, n_cnt;
    logic             r_sync_bad, n_sync_bad;
    logic [7:0]       r_sum_lo, n_sum_lo, r_sum_hi, n_sum_hi;
    logic [7:0]       r_hsum_lo, n_hsum_lo, r_hsum_hi, n_hsum_hi;
    logic [7:0]       r_type, n_type, r_cmd, n_cmd, r_len_hi, n_len_hi;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_chk, n_chk;

    logic [7:0]       w_add_lo, w_add_hi;
    logic             w_acknack, w_hdr_go, w_last;
    logic [16:0]      w_cnt_inc;
    rfd_pkg::t_status w_hdr_st;

    assign w_add_lo  = r_sum_lo + i_rx_byte;
    assign w_add_hi  = r_sum_hi + w_add_lo;
    assign w_cnt_inc = {1'b0, r_cnt} + 17'd1;
    assign w_last    = (w_cnt_inc >= {1'b0, r_len});

    assign w_acknack = (r_type == i_cfg.type_outbound) &&
                       ((r_len == i_cfg.ack_code) || (r_len == i_cfg.nack_code));

    always_comb begin
        if (r_sync_bad ||
            ((r_type != i_cfg.type_inbound) && (r_type != i_cfg.type_outbound)) ||
            ({1'b0, r_cmd} >= i_cfg.command_limit)) begin
            w_hdr_st = rfd_pkg::ST_INVALID;
        end else if (!w_acknack && (r_len > i_cfg.max_payload)) begin
            w_hdr_st = rfd_pkg::ST_INVALID;
        end else if ((r_chk != r_hsum_lo) || (i_rx_byte != r_hsum_hi)) begin
            w_hdr_st = rfd_pkg::ST_CSUM;
        end else begin
            w_hdr_st = rfd_pkg::ST_OK;
        end
    end

    assign w_hdr_go = (w_hdr_st == rfd_pkg::ST_OK) && !w_acknack && (r_len != 16'd0);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                rfd_pkg::PH_PAYLOAD: begin
                    if (w_last) n_phase = rfd_pkg::PH_CHECK;
                end
                rfd_pkg::PH_CHECK: begin
                    if (r_hidx[0]) n_phase = rfd_pkg::PH_HEADER;
                end
                default: begin
                    if ((r_hidx == 3'd7) && w_hdr_go) begin
                        n_phase = rfd_pkg::PH_PAYLOAD;
                    end else begin
                        n_phase = rfd_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    // Datapath and result records.
    always_comb begin
        n_hidx     = r_hidx;
        n_cnt      = r_cnt;
        n_sync_bad = r_sync_bad;
        n_sum_lo   = r_sum_lo;
        n_sum_hi   = r_sum_hi;
        n_hsum_lo  = r_hsum_lo;
        n_hsum_hi  = r_hsum_hi;
        n_type     = r_type;
        n_cmd      = r_cmd;
        n_len_hi   = r_len_hi;
        n_len      = r_len;
        n_chk      = r_chk;
        o_push     = 1'b0;
        o_rec.kind     = rfd_pkg::KIND_STATUS;
        o_rec.data     = 8'd0;
        o_rec.status   = rfd_pkg::ST_OK;
        o_rec.msg_type = r_type;
        o_rec.command  = r_cmd;
        o_rec.length   = r_len;
        if (i_accept) begin
            unique case (r_phase)
                rfd_pkg::PH_PAYLOAD: begin
                    n_sum_lo   = w_add_lo;
                    n_sum_hi   = w_add_hi;
                    n_cnt      = w_last ? 16'd0 : w_cnt_inc[15:0];
                    n_hidx     = 3'd0;
                    o_push     = 1'b1;
                    o_rec.kind = rfd_pkg::KIND_PAYLOAD;
                    o_rec.data = i_rx_byte;
                end
                rfd_pkg::PH_CHECK: begin
                    if (!r_hidx[0]) begin
                        n_chk  = i_rx_byte;
                        n_hidx = 3'd1;
                    end else begin
                        n_hidx       = 3'd0;
                        o_push       = 1'b1;
                        o_rec.status = ((r_chk == r_sum_lo) && (i_rx_byte == r_sum_hi)) ?
                                       rfd_pkg::ST_OK : rfd_pkg::ST_CSUM;
                    end
                end
                default: begin
                    n_hidx = (r_phase == rfd_pkg::PH_HEADER) ? r_hidx + 3'd1 : 3'd1;
                    case ((r_phase == rfd_pkg::PH_HEADER) ? r_hidx : 3'd0)
                        3'd0: begin
                            n_sync_bad = (i_rx_byte != i_cfg.sync_first);
                            n_sum_lo   = 8'd0;
                            n_sum_hi   = 8'd0;
                        end
                        3'd1: begin
                            if (i_rx_byte != i_cfg.sync_second) n_sync_bad = 1'b1;
                        end
                        3'd2: begin
                            n_type   = i_rx_byte;
                            n_sum_lo = w_add_lo;
                            n_sum_hi = w_add_hi;
                        end
                        3'd3: begin
                            n_cmd    = i_rx_byte;
                            n_sum_lo = w_add_lo;
                            n_sum_hi = w_add_hi;
                        end
                        3'd4: begin
                            n_len_hi = i_rx_byte;
                            n_sum_lo = w_add_lo;
                            n_sum_hi = w_add_hi;
                        end
                        3'd5: begin
                            n_len     = {r_len_hi, i_rx_byte};
                            n_sum_lo  = w_add_lo;
                            n_sum_hi  = w_add_hi;
                            n_hsum_lo = w_add_lo;
                            n_hsum_hi = w_add_hi;
                        end
                        3'd6: begin
                            n_chk    = i_rx_byte;
                            n_sum_lo = w_add_lo;
                            n_sum_hi = w_add_hi;
                        end
                        default: begin
                            n_sum_lo     = w_add_lo;
                            n_sum_hi     = w_add_hi;
                            n_hidx       = 3'd0;
                            n_cnt        = 16'd0;
                            o_push       = !w_hdr_go;
                            o_rec.status = w_hdr_st;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rfd_pkg::PH_HEADER;
            r_hidx  <= 3'd0;
        end else begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_sync_bad <= n_sync_bad;
        r_sum_lo   <= n_sum_lo;
        r_sum_hi   <= n_sum_hi;
        r_hsum_lo  <= n_hsum_lo;
        r_hsum_hi  <= n_hsum_hi;
        r_type     <= n_type;
        r_cmd      <= n_cmd;
        r_len_hi   <= n_len_hi;
        r_len      <= n_len;
        r_chk      <= n_chk;
    end

endmodule

/* design/rfd_queue.sv */
// Short record queue between the front and back parts of the radio frame
// deframer. Depends on rfd_pkg for the record type and the depth.
module rfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rfd_pkg::t_rec i_rec,
    input  logic          i_pop,
    output rfd_pkg::t_rec o_rec,
    output logic          o_empty,
    output logic          o_full
);
    rfd_pkg::t_rec                 r_mem [rfd_pkg::QDEPTH];
    logic [rfd_pkg::QPTR_W-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [rfd_pkg::QCNT_W-1:0]    r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == rfd_pkg::QCNT_W'(rfd_pkg::QDEPTH));
    assign o_rec   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) n_wp = r_wp + 1'b1;
        if (i_pop)  n_rp = r_rp + 1'b1;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

endmodule

/* design/rfd_back.sv */
// Back part of the radio frame deframer: takes records from the queue, works
// out the ack, nack and inbound flags and holds the output item. Uses rfd_pkg.
module rfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rfd_pkg::t_cfg i_cfg,
    input  rfd_pkg::t_rec i_rec,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output logic          o_item_kind,
    output logic [7:0]    o_payload_byte,
    output logic [1:0]    o_status,
    output logic [7:0]    o_msg_type,
    output logic [7:0]    o_command_code,
    output logic [15:0]   o_length_field,
    output logic          o_is_ack,
    output logic          o_is_nack,
    output logic          o_is_inbound
);
    logic          r_valid, n_valid;
    rfd_pkg::t_rec r_rec;
    logic          r_ack, r_nack, r_inb;
    logic          w_outb;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign w_outb  = (i_rec.msg_type == i_cfg.type_outbound);
    assign n_valid = o_pop || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec  <= i_rec;
            r_ack  <= w_outb && (i_rec.length == i_cfg.ack_code);
            r_nack <= w_outb && (i_rec.length == i_cfg.nack_code);
            r_inb  <= (i_rec.msg_type == i_cfg.type_inbound);
        end
    end

    assign o_valid        = r_valid;
    assign o_item_kind    = r_rec.kind;
    assign o_payload_byte = r_rec.data;
    assign o_status       = r_rec.status;
    assign o_msg_type     = r_rec.msg_type;
    assign o_command_code = r_rec.command;
    assign o_length_field = r_rec.length;
    assign o_is_ack       = r_ack;
    assign o_is_nack      = r_nack;
    assign o_is_inbound   = r_inb;

endmodule

/* design/rfd_checker.sv */
// Port-level checker for the radio frame deframer, bound to the top level.
// Depends on rfd_pkg for the item kinds and status codes.
module rfd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic [7:0]                     i_rx_byte,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_item_kind,
    input logic [7:0]                     o_payload_byte,
    input logic [1:0]                     o_status,
    input logic [7:0]                     o_msg_type,
    input logic [7:0]                     o_command_code,
    input logic [15:0]                    o_length_field,
    input logic                           o_is_ack,
    input logic                           o_is_nack,
    input logic                           o_is_inbound,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [rfd_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [rfd_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [rfd_pkg::CFG_DATA_W-1:0] prdata,
    input logic                           pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_payload_byte) &&
        $stable(o_status) && $stable(o_item_kind) && $stable(o_length_field))
        else $error("output item changed while stalled");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == rfd_pkg::KIND_PAYLOAD) |-> (o_status == rfd_pkg::ST_OK))
        else $error("payload item carries a nonzero status");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == rfd_pkg::KIND_STATUS) |-> (o_payload_byte == 8'd0))
        else $error("status item carries a data byte");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == rfd_pkg::ST_OK) || (o_status == rfd_pkg::ST_INVALID) ||
        (o_status == rfd_pkg::ST_CSUM))
        else $error("unknown status code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && pready)
        else $error("output valid right after reset");

endmodule

bind radio_frame_deframer rfd_checker u_rfd_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for radio_frame_deframer: sends headers, payloads and noise,
// predicts every payload and status item and compares them. Depends on rfd_pkg and the RTL.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 100;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic             kind;
        logic [7:0]       data;
        rfd_pkg::t_status status;
        logic [7:0]       msg_type;
        logic [7:0]       command;
        logic [15:0]      length;
        logic             ack;
        logic             nack;
        logic             inbound;
    } t_frame_item;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [7:0]                     i_rx_byte = 8'h00;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic                           o_item_kind;
    logic [7:0]                     o_payload_byte;
    logic [1:0]                     o_status;
    logic [7:0]                     o_msg_type;
    logic [7:0]                     o_command_code;
    logic [15:0]                    o_length_field;
    logic                           o_is_ack;
    logic                           o_is_nack;
    logic                           o_is_inbound;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [rfd_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [rfd_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [rfd_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    radio_frame_deframer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_item_kind    (o_item_kind),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_msg_type     (o_msg_type),
        .o_command_code (o_command_code),
        .o_length_field (o_length_field),
        .o_is_ack       (o_is_ack),
        .o_is_nack      (o_is_nack),
        .o_is_inbound   (o_is_inbound),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Deframer state as predicted from the accepted bytes.
    rfd_pkg::t_cfg   cfg;
    rfd_pkg::t_phase ph;
    logic [16:0]     pos;
    logic [7:0]      run_lo, run_hi, hdr_lo, hdr_hi, csum_lo;
    logic [7:0]      hold [4];
    logic [15:0]     plen;
    logic            sync_err;

    t_frame_item deframed_q [$];
    t_frame_item got;
    int          n_sent;
    int          n_errors;
    int          quiet_cycles;
    int          hold_left, gap_left;
    bit          hold_req, idle_allowed, idle_tx, idle_rx;

    function automatic void reset_model();
        cfg.sync_first    = rfd_pkg::RST_SYNC_FIRST;
        cfg.sync_second   = rfd_pkg::RST_SYNC_SECOND;
        cfg.type_inbound  = rfd_pkg::RST_TYPE_INBOUND;
        cfg.type_outbound = rfd_pkg::RST_TYPE_OUTBOUND;
        cfg.command_limit = rfd_pkg::RST_COMMAND_LIMIT;
        cfg.ack_code      = rfd_pkg::RST_ACK_CODE;
        cfg.nack_code     = rfd_pkg::RST_NACK_CODE;
        cfg.max_payload   = rfd_pkg::RST_MAX_PAYLOAD;
        ph = rfd_pkg::PH_HEADER;
        pos = '0;
        run_lo = '0;
        run_hi = '0;
        hdr_lo = '0;
        hdr_hi = '0;
        csum_lo = '0;
        foreach (hold[k]) hold[k] = '0;
        plen = '0;
        sync_err = 1'b0;
    endfunction

    function automatic void add_sum(logic [7:0] b);
        run_lo = run_lo + b;
        run_hi = run_hi + run_lo;
    endfunction

    function automatic t_frame_item make_item(logic kind, logic [7:0] data,
                                              rfd_pkg::t_status st);
        t_frame_item it;
        it.kind     = kind;
        it.data     = data;
        it.status   = st;
        it.msg_type = hold[0];
        it.command  = hold[1];
        it.length   = plen;
        it.ack      = (hold[0] == cfg.type_outbound) && (plen == cfg.ack_code);
        it.nack     = (hold[0] == cfg.type_outbound) && (plen == cfg.nack_code);
        it.inbound  = (hold[0] == cfg.type_inbound);
        return it;
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [16:0]      idx;
        logic             acknack;
        rfd_pkg::t_status st;
        case (ph)
            rfd_pkg::PH_PAYLOAD: begin
                add_sum(b);
                deframed_q.push_back(make_item(rfd_pkg::KIND_PAYLOAD, b, rfd_pkg::ST_OK));
                pos = pos + 1'b1;
                if (pos >= plen) begin
                    ph = rfd_pkg::PH_CHECK;
                    pos = '0;
                end
            end
            rfd_pkg::PH_CHECK: begin
                if (pos == 0) begin
                    csum_lo = b;
                    pos = 17'd1;
                end else begin
                    ph = rfd_pkg::PH_HEADER;
                    pos = '0;
                    if (csum_lo == run_lo && b == run_hi) st = rfd_pkg::ST_OK;
                    else st = rfd_pkg::ST_CSUM;
                    deframed_q.push_back(make_item(rfd_pkg::KIND_STATUS, 8'h00, st));
                end
            end
            default: begin
                if (ph != rfd_pkg::PH_HEADER || pos > 7) begin
                    ph = rfd_pkg::PH_HEADER;
                    pos = '0;
                end
                idx = pos;
                pos = idx + 1'b1;
                if (idx == 0) begin
                    sync_err = (b != cfg.sync_first);
                    run_lo = '0;
                    run_hi = '0;
                end else if (idx == 1) begin
                    if (b != cfg.sync_second) sync_err = 1'b1;
                end else if (idx <= 5) begin
                    hold[idx[1:0] - 2'd2] = b;
                    add_sum(b);
                    if (idx == 5) begin
                        hdr_lo = run_lo;
                        hdr_hi = run_hi;
                        plen = {hold[2], hold[3]};
                    end
                end else if (idx == 6) begin
                    csum_lo = b;
                    add_sum(b);
                end else begin
                    add_sum(b);
                    pos = '0;
                    acknack = (hold[0] == cfg.type_outbound) &&
                              (plen == cfg.ack_code || plen == cfg.nack_code);
                    if (sync_err ||
                        (hold[0] != cfg.type_inbound && hold[0] != cfg.type_outbound) ||
                        {1'b0, hold[1]} >= cfg.command_limit) st = rfd_pkg::ST_INVALID;
                    else if (!acknack && plen > cfg.max_payload) st = rfd_pkg::ST_INVALID;
                    else if (csum_lo != hdr_lo || b != hdr_hi) st = rfd_pkg::ST_CSUM;
                    else st = rfd_pkg::ST_OK;
                    if (st == rfd_pkg::ST_OK && !acknack && plen != 0) begin
                        ph = rfd_pkg::PH_PAYLOAD;
                    end else begin
                        deframed_q.push_back(make_item(rfd_pkg::KIND_STATUS, 8'h00, st));
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (deframed_q.size() == 0) begin
                $error("item_kind: expected nothing, got %0h", o_item_kind);
                n_errors++;
            end else begin
                got = deframed_q.pop_front();
                check_field("item_kind", 16'(got.kind), 16'(o_item_kind));
                check_field("payload_byte", 16'(got.data), 16'(o_payload_byte));
                check_field("status", 16'(got.status), 16'(o_status));
                check_field("msg_type", 16'(got.msg_type), 16'(o_msg_type));
                check_field("command_code", 16'(got.command), 16'(o_command_code));
                check_field("length_field", got.length, o_length_field);
                check_field("is_ack", 16'(got.ack), 16'(o_is_ack));
                check_field("is_nack", 16'(got.nack), 16'(o_is_nack));
                check_field("is_inbound", 16'(got.inbound), 16'(o_is_inbound));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_ready <= 1'b0;
        end else if (idle_rx && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        deframe_byte(b);
        n_sent++;
        if (idle_tx && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rfd_pkg::t_reg_idx idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            rfd_pkg::REG_SYNC_FIRST:    cfg.sync_first    = v[7:0];
            rfd_pkg::REG_SYNC_SECOND:   cfg.sync_second   = v[7:0];
            rfd_pkg::REG_TYPE_INBOUND:  cfg.type_inbound  = v[7:0];
            rfd_pkg::REG_TYPE_OUTBOUND: cfg.type_outbound = v[7:0];
            rfd_pkg::REG_COMMAND_LIMIT: cfg.command_limit = v[8:0];
            rfd_pkg::REG_ACK_CODE:      cfg.ack_code      = v[15:0];
            rfd_pkg::REG_NACK_CODE:     cfg.nack_code     = v[15:0];
            default:                    cfg.max_payload   = v[15:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] s1, s2, ti, to, input logic [8:0] cl,
                                input logic [15:0] ack, nack, mp);
        wait_results();
        write_reg(rfd_pkg::REG_SYNC_FIRST, 32'(s1));
        write_reg(rfd_pkg::REG_SYNC_SECOND, 32'(s2));
        write_reg(rfd_pkg::REG_TYPE_INBOUND, 32'(ti));
        write_reg(rfd_pkg::REG_TYPE_OUTBOUND, 32'(to));
        write_reg(rfd_pkg::REG_COMMAND_LIMIT, 32'(cl));
        write_reg(rfd_pkg::REG_ACK_CODE, 32'(ack));
        write_reg(rfd_pkg::REG_NACK_CODE, 32'(nack));
        write_reg(rfd_pkg::REG_MAX_PAYLOAD, 32'(mp));
    endtask

    // Bytes left over from noise are flushed until the deframer waits for a sync byte.
    task automatic send_frame(input logic [7:0] s1, s2, ty, cm, input logic [15:0] len,
                              input logic [15:0] herr, berr, input int fill);
        logic [7:0] lo, hi;
        logic [7:0] hb [4];
        while (!(ph == rfd_pkg::PH_HEADER && pos == 0)) send_byte(8'($urandom));
        hb = '{ty, cm, len[15:8], len[7:0]};
        lo = '0;
        hi = '0;
        foreach (hb[k]) begin
            lo = lo + hb[k];
            hi = hi + lo;
        end
        send_byte(s1);
        send_byte(s2);
        foreach (hb[k]) send_byte(hb[k]);
        send_byte(lo ^ herr[7:0]);
        send_byte(hi ^ herr[15:8]);
        if (ph == rfd_pkg::PH_PAYLOAD) begin
            repeat (plen) send_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
            send_byte(run_lo ^ berr[7:0]);
            send_byte(run_hi ^ berr[15:8]);
        end
    endtask

    task automatic random_frame(input int flaw);
        logic [7:0]  s1, s2, ty, cm;
        logic [15:0] len, herr, berr;
        int          mp, cl, cap;
        mp = cfg.max_payload;
        cl = cfg.command_limit;
        s1 = cfg.sync_first;
        s2 = cfg.sync_second;
        ty = $urandom_range(0, 1) ? cfg.type_inbound : cfg.type_outbound;
        cm = (cl == 0) ? 8'($urandom) : 8'($urandom_range(0, cl - 1));
        cap = (mp < 16) ? mp : 16;
        if ($urandom_range(0, 29) == 0) cap = (mp < 300) ? mp : 300;
        len = 16'($urandom_range(0, cap));
        if (ty == cfg.type_outbound && $urandom_range(0, 4) == 0)
            len = $urandom_range(0, 1) ? cfg.ack_code : cfg.nack_code;
        herr = ($urandom_range(0, 9) == 0) ? 16'h0001 << $urandom_range(0, 15) : 16'h0000;
        berr = ($urandom_range(0, 6) == 0) ? 16'h0001 << $urandom_range(0, 15) : 16'h0000;
        case (flaw)
            1: s1 = s1 ^ (8'h01 << $urandom_range(0, 7));
            2: s2 = s2 ^ (8'h01 << $urandom_range(0, 7));
            3: ty = 8'($urandom);
            4: cm = (cl > 255) ? 8'($urandom) : 8'($urandom_range(cl, 255));
            5: if (mp < 65535) len = 16'($urandom_range(mp + 1, 65535));
            default: ;
        endcase
        send_frame(s1, s2, ty, cm, len, herr, berr, -1);
    endtask

    task automatic test_random(input int n);
        int start;
        int pick;
        start = n_sent;
        while (n_sent - start < n) begin
            idle_tx = idle_allowed && ($urandom_range(0, 3) != 0);
            idle_rx = idle_allowed && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) random_frame(0);
            else if (pick < 9) random_frame($urandom_range(1, 5));
            else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_frame(cfg.sync_first, cfg.sync_second, cfg.type_inbound, 8'd63, 16'd1,
                   16'h0000, 16'h0001, 255);
        send_frame(cfg.sync_first, cfg.sync_second, cfg.type_outbound, 8'h00,
                   cfg.nack_code, 16'h0100, 16'h0000, 0);
        send_frame(cfg.sync_first, cfg.sync_second, cfg.type_outbound, 8'd64,
                   cfg.ack_code, 16'h0000, 16'h0000, 0);
        send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 0);
    endtask

    task automatic test_backpressure();
        idle_tx = 1'b0;
        idle_rx = 1'b0;
        hold_req = 1'b1;
        repeat (6) send_frame(cfg.sync_first, cfg.sync_second, cfg.type_inbound, 8'h00,
                              16'($urandom_range(8, 20)), 16'h0000, 16'h0000, -1);
        wait_results();
        repeat (6) random_frame(0);
    endtask

    task automatic test_tail();
        send_frame(cfg.sync_first, cfg.sync_second, cfg.type_outbound, 8'h01,
                   cfg.max_payload, 16'h0000, 16'h0000, -1);
        test_random(150);
    endtask

    initial begin
        n_sent = 0;
        n_errors = 0;
        quiet_cycles = 0;
        hold_left = 0;
        gap_left = 0;
        hold_req = 1'b0;
        idle_allowed = 1'b1;
        idle_tx = 1'b1;
        idle_rx = 1'b1;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(200);

        write_config(8'h00, 8'hFF, 8'h5A, 8'h5A, 9'd256, 16'h0003, 16'h0003, 16'h0000);
        test_random(150);

        write_config(8'hFF, 8'h00, 8'hFF, 8'h00, 9'd1, 16'hFFFF, 16'h0000, 16'hFFFF);
        test_random(250);

        write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 9'd0,
                     16'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
        test_random(100);

        write_config(rfd_pkg::RST_SYNC_FIRST, rfd_pkg::RST_SYNC_SECOND,
                     rfd_pkg::RST_TYPE_INBOUND, rfd_pkg::RST_TYPE_OUTBOUND,
                     rfd_pkg::RST_COMMAND_LIMIT, rfd_pkg::RST_ACK_CODE,
                     rfd_pkg::RST_NACK_CODE, 16'd300);
        test_backpressure();

        idle_allowed = 1'b0;
        idle_tx = 1'b0;
        idle_rx = 1'b0;
        test_tail();

        wait_results();
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
